// ----- sv/fpe_pkg.sv -----
// Shared types, constants and plane tables for the frustum plane block.
// Used by the interfaces, the controller, the datapath and the top level.
`default_nettype none

package fpe_pkg;

    localparam int DATA_W   = 32;   // Q format word
    localparam int SUM_W    = 33;   // exact plane sum or difference
    localparam int ROOT_W   = 34;   // integer square root of the squared length
    localparam int ACC_W    = 66;   // squared length or dot product accumulator
    localparam int FRAC_DEF = 16;

    localparam logic [2:0] LAST_PLANE = 3'd5;
    localparam logic [1:0] W_ROW      = 2'd3;

    localparam logic [1:0] OP_LOAD      = 2'd0;
    localparam logic [1:0] OP_RECOMPUTE = 2'd1;
    localparam logic [1:0] OP_QUERY     = 2'd2;
    localparam logic [1:0] OP_RESERVED  = 2'd3;

    localparam logic KIND_PLANE = 1'b0;
    localparam logic KIND_DIST  = 1'b1;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_LATCH_PT,
        DP_GATHER,
        DP_ACCUM,
        DP_SQRT_INIT,
        DP_SQRT_STEP,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_DIV_STORE,
        DP_PLANE_WR,
        DP_QFIN
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic       query;
        logic [2:0] step;
        logic [1:0] comp;
        logic [2:0] plane;
    } t_dp_cmd;

    typedef struct packed {
        logic zero_len;
    } t_dp_sts;

    // Matrix row that is combined with the last row for each plane.
    function automatic logic [1:0] plane_row(input logic [2:0] p);
        logic [1:0] r;
        case (p) inside
            3'd0, 3'd1: r = 2'd2;
            3'd2, 3'd3: r = 2'd0;
            default:    r = 2'd1;
        endcase
        return r;
    endfunction

    // One when the plane adds the row to the last row, zero when it subtracts.
    function automatic logic plane_add(input logic [2:0] p);
        logic a;
        case (p) inside
            3'd0, 3'd2, 3'd5: a = 1'b1;
            default:          a = 1'b0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ----- sv/fpe_ifs.sv -----
// Valid/ready channel interfaces for input items and result items.
// Depends on fpe_pkg for the word width.
`default_nettype none

interface fpe_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          operation;
    logic [1:0]                          column_index;
    logic [1:0]                          row_index;
    logic signed [fpe_pkg::DATA_W-1:0]   element_value;
    logic signed [fpe_pkg::DATA_W-1:0]   point_x;
    logic signed [fpe_pkg::DATA_W-1:0]   point_y;
    logic signed [fpe_pkg::DATA_W-1:0]   point_z;

    modport source  (output valid, operation, column_index, row_index, element_value,
                     point_x, point_y, point_z, input ready);
    modport sink    (input valid, operation, column_index, row_index, element_value,
                     point_x, point_y, point_z, output ready);
    modport monitor (input valid, operation, column_index, row_index, element_value,
                     point_x, point_y, point_z, ready);
endinterface

interface fpe_out_if;
    logic                                valid;
    logic                                ready;
    logic                                result_kind;
    logic [2:0]                          plane_index;
    logic signed [fpe_pkg::DATA_W-1:0]   normal_x;
    logic signed [fpe_pkg::DATA_W-1:0]   normal_y;
    logic signed [fpe_pkg::DATA_W-1:0]   normal_z;
    logic signed [fpe_pkg::DATA_W-1:0]   plane_offset;
    logic signed [fpe_pkg::DATA_W-1:0]   point_distance;
    logic                                degenerate;
    logic                                last_result;

    modport source  (output valid, result_kind, plane_index, normal_x, normal_y, normal_z,
                     plane_offset, point_distance, degenerate, last_result, input ready);
    modport sink    (input valid, result_kind, plane_index, normal_x, normal_y, normal_z,
                     plane_offset, point_distance, degenerate, last_result, output ready);
    modport monitor (input valid, result_kind, plane_index, normal_x, normal_y, normal_z,
                     plane_offset, point_distance, degenerate, last_result, ready);
endinterface

`default_nettype wire

// ----- sv/frustum_plane_extract_and_test.sv -----
// Channel    | Dir | Transaction
// i_in       | in  | load element, recompute planes, or point query
// o_out      | out | one plane or one distance; six per recompute or query
//
// Load stores one matrix element and leaves the block idle. Query, per plane: three
// products on the shared multiplier, drain, saturate, emit. Recompute, per plane:
// gather, square, zero-length test, square root, one bit-serial divide per
// coefficient, plane write and emit; a zero length goes straight to the plane write.
// Reset is synchronous; all stores read as zero after reset. An output stall
// holds the current result; no new transaction is taken until a run ends.
// Top level; depends on fpe_pkg, fpe_ifs, fpe_ctrl and fpe_dp.
`default_nettype none

module frustum_plane_extract_and_test #(
    parameter int FRACTION_BITS = fpe_pkg::FRAC_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fpe_in_if.sink     i_in,
    fpe_out_if.source  o_out
);

    fpe_pkg::t_dp_cmd cmd;
    fpe_pkg::t_dp_sts sts;

    fpe_ctrl #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in.valid),
        .i_in_operation (i_in.operation),
        .o_in_ready     (i_in.ready),
        .o_out_valid    (o_out.valid),
        .o_out_kind     (o_out.result_kind),
        .i_out_ready    (o_out.ready),
        .o_cmd          (cmd),
        .i_sts          (sts)
    );

    fpe_dp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_column_index   (i_in.column_index),
        .i_row_index      (i_in.row_index),
        .i_element_value  (i_in.element_value),
        .i_point_x        (i_in.point_x),
        .i_point_y        (i_in.point_y),
        .i_point_z        (i_in.point_z),
        .o_plane_index    (o_out.plane_index),
        .o_normal_x       (o_out.normal_x),
        .o_normal_y       (o_out.normal_y),
        .o_normal_z       (o_out.normal_z),
        .o_plane_offset   (o_out.plane_offset),
        .o_point_distance (o_out.point_distance),
        .o_degenerate     (o_out.degenerate),
        .o_last_result    (o_out.last_result)
    );

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input taken while a result is pending");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_result) |=> i_in.ready)
        else $error("block not idle after the last result of a run");

    a_plane_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.result_kind == fpe_pkg::KIND_PLANE) |->
        o_out.point_distance == '0)
        else $error("plane result carries a nonzero distance");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.degenerate) |->
        (o_out.normal_x == '0 && o_out.normal_y == '0 &&
         o_out.normal_z == '0 && o_out.plane_offset == '0))
        else $error("degenerate plane with nonzero coefficients");
`endif

endmodule

`default_nettype wire

// ----- sv/fpe_ctrl.sv -----
// Sequencer for plane recompute and point query runs; also issues element loads.
// Depends on fpe_pkg; drives fpe_dp through a command struct.
`default_nettype none

module fpe_ctrl #(
    parameter int FRACTION_BITS = fpe_pkg::FRAC_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_in_operation,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output logic              o_out_kind,
    input  logic              i_out_ready,
    output fpe_pkg::t_dp_cmd  o_cmd,
    input  fpe_pkg::t_dp_sts  i_sts
);

    localparam int DIV_STEPS  = fpe_pkg::SUM_W + FRACTION_BITS;
    localparam int SQRT_STEPS = fpe_pkg::ROOT_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [CNT_W-1:0] GATHER_LAST = CNT_W'(7);
    localparam logic [CNT_W-1:0] ACC_LAST    = CNT_W'(3);
    localparam logic [CNT_W-1:0] SQRT_LAST   = CNT_W'(SQRT_STEPS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(DIV_STEPS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_GATHER, S_SQ, S_TEST, S_SQRT, S_DIV_INIT, S_DIV, S_DIV_STORE,
        S_WR, S_QMUL, S_QFIN, S_EMIT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [1:0]       r_comp;
    logic [2:0]       r_plane;
    logic             r_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_comp  <= '0;
            r_plane <= '0;
            r_kind  <= fpe_pkg::KIND_PLANE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cnt   <= '0;
                        r_comp  <= '0;
                        r_plane <= '0;
                        case (i_in_operation)
                            fpe_pkg::OP_RECOMPUTE: begin
                                r_kind  <= fpe_pkg::KIND_PLANE;
                                r_state <= S_GATHER;
                            end
                            fpe_pkg::OP_QUERY: begin
                                r_kind  <= fpe_pkg::KIND_DIST;
                                r_state <= S_QMUL;
                            end
                            default: ;
                        endcase
                    end
                end
                S_GATHER: begin
                    r_cnt <= (r_cnt == GATHER_LAST) ? '0 : r_cnt + CNT_W'(1);
                    if (r_cnt == GATHER_LAST) r_state <= S_SQ;
                end
                S_SQ: begin
                    r_cnt <= (r_cnt == ACC_LAST) ? '0 : r_cnt + CNT_W'(1);
                    if (r_cnt == ACC_LAST) r_state <= S_TEST;
                end
                S_TEST: begin
                    r_state <= i_sts.zero_len ? S_WR : S_SQRT;
                end
                S_SQRT: begin
                    r_cnt <= (r_cnt == SQRT_LAST) ? '0 : r_cnt + CNT_W'(1);
                    if (r_cnt == SQRT_LAST) begin
                        r_comp  <= '0;
                        r_state <= S_DIV_INIT;
                    end
                end
                S_DIV_INIT: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= (r_cnt == DIV_LAST) ? '0 : r_cnt + CNT_W'(1);
                    if (r_cnt == DIV_LAST) r_state <= S_DIV_STORE;
                end
                S_DIV_STORE: begin
                    if (r_comp == 2'd3) begin
                        r_state <= S_WR;
                    end else begin
                        r_comp  <= r_comp + 2'd1;
                        r_state <= S_DIV_INIT;
                    end
                end
                S_WR: begin
                    r_state <= S_EMIT;
                end
                S_QMUL: begin
                    r_cnt <= (r_cnt == ACC_LAST) ? '0 : r_cnt + CNT_W'(1);
                    if (r_cnt == ACC_LAST) r_state <= S_QFIN;
                end
                S_QFIN: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (i_out_ready) begin
                        r_cnt <= '0;
                        if (r_plane == fpe_pkg::LAST_PLANE) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_plane <= r_plane + 3'd1;
                            r_state <= (r_kind == fpe_pkg::KIND_DIST) ? S_QMUL : S_GATHER;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd.op    = fpe_pkg::DP_NOP;
        o_cmd.query = r_kind;
        o_cmd.step  = r_cnt[2:0];
        o_cmd.comp  = r_comp;
        o_cmd.plane = r_plane;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_in_operation == fpe_pkg::OP_LOAD)
                    o_cmd.op = fpe_pkg::DP_LOAD;
                else if (i_in_valid && i_in_operation == fpe_pkg::OP_QUERY)
                    o_cmd.op = fpe_pkg::DP_LATCH_PT;
            end
            S_GATHER:    o_cmd.op = fpe_pkg::DP_GATHER;
            S_SQ:        o_cmd.op = fpe_pkg::DP_ACCUM;
            S_QMUL:      o_cmd.op = fpe_pkg::DP_ACCUM;
            S_TEST:      o_cmd.op = fpe_pkg::DP_SQRT_INIT;
            S_SQRT:      o_cmd.op = fpe_pkg::DP_SQRT_STEP;
            S_DIV_INIT:  o_cmd.op = fpe_pkg::DP_DIV_INIT;
            S_DIV:       o_cmd.op = fpe_pkg::DP_DIV_STEP;
            S_DIV_STORE: o_cmd.op = fpe_pkg::DP_DIV_STORE;
            S_WR:        o_cmd.op = fpe_pkg::DP_PLANE_WR;
            S_QFIN:      o_cmd.op = fpe_pkg::DP_QFIN;
            default:     o_cmd.op = fpe_pkg::DP_NOP;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);
    assign o_out_kind  = r_kind;

endmodule

`default_nettype wire

// ----- sv/fpe_dp.sv -----
// Datapath: matrix and plane storage, shared multiplier, square root and divider.
// Depends on fpe_pkg; driven by the command struct from fpe_ctrl.
`default_nettype none

module fpe_dp #(
    parameter int FRACTION_BITS = fpe_pkg::FRAC_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fpe_pkg::t_dp_cmd                   i_cmd,
    output fpe_pkg::t_dp_sts                   o_sts,
    input  logic [1:0]                         i_column_index,
    input  logic [1:0]                         i_row_index,
    input  logic signed [fpe_pkg::DATA_W-1:0]  i_element_value,
    input  logic signed [fpe_pkg::DATA_W-1:0]  i_point_x,
    input  logic signed [fpe_pkg::DATA_W-1:0]  i_point_y,
    input  logic signed [fpe_pkg::DATA_W-1:0]  i_point_z,
    output logic [2:0]                         o_plane_index,
    output logic signed [fpe_pkg::DATA_W-1:0]  o_normal_x,
    output logic signed [fpe_pkg::DATA_W-1:0]  o_normal_y,
    output logic signed [fpe_pkg::DATA_W-1:0]  o_normal_z,
    output logic signed [fpe_pkg::DATA_W-1:0]  o_plane_offset,
    output logic signed [fpe_pkg::DATA_W-1:0]  o_point_distance,
    output logic                               o_degenerate,
    output logic                               o_last_result
);

    localparam int DW     = fpe_pkg::DATA_W;
    localparam int SW     = fpe_pkg::SUM_W;
    localparam int RW     = fpe_pkg::ROOT_W;
    localparam int AW     = fpe_pkg::ACC_W;
    localparam int NW     = SW + FRACTION_BITS;
    localparam int SREM_W = RW + 3;

    localparam logic [AW-1:0] HALF_LSB  = AW'(1) << (FRACTION_BITS - 1);
    localparam logic [AW-1:0] TOP_SQ    = AW'(1) << (2 * DW);
    localparam logic [NW-1:0] POS_LIMIT = NW'(32'h7fff_ffff);
    localparam logic [NW-1:0] NEG_LIMIT = NW'(32'h8000_0000);

    typedef logic signed [DW-1:0] t_word;
    typedef logic [3:0][DW-1:0]   t_plane;   // x, y, z, offset from index 0

    t_word                r_mat [16];
    logic [15:0]          r_mat_vld;
    t_plane               r_pln [6];
    logic [5:0]           r_pln_vld;
    logic [5:0]           r_degen;

    t_word                r_w;
    logic signed [SW-1:0] r_v [4];
    t_word                r_px, r_py, r_pz;
    logic signed [AW-1:0] r_prod;
    logic                 r_sqh;
    logic signed [AW-1:0] r_acc;
    logic [AW+1:0]        r_sval;
    logic [SREM_W-1:0]    r_srem;
    logic [RW-1:0]        r_root;
    logic [RW-1:0]        r_rem;
    logic [NW-1:0]        r_nq;
    logic                 r_neg;
    t_word                r_res [4];
    t_word                r_dist;

    // Matrix read: even gather steps fetch the last row, odd ones the plane's row.
    logic [3:0]           mat_addr;
    t_word                mat_rd;
    logic signed [SW-1:0] ext_w, ext_e;
    t_plane               pln_rd;

    assign mat_addr = {i_cmd.step[2:1], i_cmd.step[0] ? fpe_pkg::plane_row(i_cmd.plane)
                                                      : fpe_pkg::W_ROW};
    assign mat_rd   = r_mat_vld[mat_addr] ? r_mat[mat_addr] : '0;
    assign ext_w    = {r_w[DW-1], r_w};
    assign ext_e    = {mat_rd[DW-1], mat_rd};
    assign pln_rd   = r_pln_vld[i_cmd.plane] ? r_pln[i_cmd.plane] : '0;

    // Shared multiplier: squares of plane sums, or point times normal.
    logic signed [SW-1:0] sq_v;
    logic [SW-1:0]        sq_mag;
    t_word                q_p;
    logic signed [SW-1:0] mul_a, mul_b;
    logic signed [AW-1:0] mul_p;

    assign sq_v   = r_v[i_cmd.step[1:0]];
    assign sq_mag = sq_v[SW-1] ? -sq_v : sq_v;

    always_comb begin
        case (i_cmd.step[1:0])
            2'd0:    q_p = r_px;
            2'd1:    q_p = r_py;
            default: q_p = r_pz;
        endcase
    end

    assign mul_a = i_cmd.query ? {q_p[DW-1], q_p} : {1'b0, sq_mag[DW-1:0]};
    assign mul_b = i_cmd.query ? {pln_rd[i_cmd.step[1:0]][DW-1], pln_rd[i_cmd.step[1:0]]}
                               : {1'b0, sq_mag[DW-1:0]};
    assign mul_p = mul_a * mul_b;

    // A magnitude of exactly 2^32 has zero low bits, so its square is only the top term.
    logic signed [AW-1:0] acc_add;
    assign acc_add = r_prod + (r_sqh ? TOP_SQ : '0);

    // Square root, two bits of the radicand per step.
    logic [SREM_W-1:0] srem_sh, strial;
    assign srem_sh = {r_srem[SREM_W-3:0], r_sval[AW+1:AW]};
    assign strial  = SREM_W'({r_root, 2'b01});

    // Restoring divider, one quotient bit per step.
    logic signed [SW-1:0] div_v;
    logic [SW-1:0]        div_mag;
    logic [RW:0]          rem_sh, dtrial;
    logic [NW-1:0]        q;
    t_word                q_sat;

    assign div_v   = r_v[i_cmd.comp];
    assign div_mag = div_v[SW-1] ? -div_v : div_v;
    assign rem_sh  = {r_rem, r_nq[NW-1]};
    assign dtrial  = rem_sh - {1'b0, r_root};
    assign q       = r_nq;

    always_comb begin
        if (r_neg)
            q_sat = (q > NEG_LIMIT) ? t_word'(32'h8000_0000) : -t_word'(q[DW-1:0]);
        else
            q_sat = (q > POS_LIMIT) ? t_word'(32'h7fff_ffff) : t_word'(q[DW-1:0]);
    end

    // Distance: floor shift of the rounded dot product, plus offset, saturated.
    logic signed [AW-1:0] acc_sh;
    logic signed [AW:0]   dsum;
    logic                 dfits;
    t_word                dist_sat;

    assign acc_sh   = r_acc >>> FRACTION_BITS;
    assign dsum     = {acc_sh[AW-1], acc_sh}
                      + {{(AW + 1 - DW){pln_rd[3][DW-1]}}, pln_rd[3]};
    assign dfits    = (&dsum[AW:DW-1]) | ~(|dsum[AW:DW-1]);
    assign dist_sat = dfits ? dsum[DW-1:0]
                            : (dsum[AW] ? t_word'(32'h8000_0000) : t_word'(32'h7fff_ffff));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat_vld <= '0;
            r_pln_vld <= '0;
            r_degen   <= '0;
        end else begin
            case (i_cmd.op)
                fpe_pkg::DP_LOAD: r_mat_vld[{i_column_index, i_row_index}] <= 1'b1;
                fpe_pkg::DP_PLANE_WR: begin
                    r_pln_vld[i_cmd.plane] <= 1'b1;
                    r_degen[i_cmd.plane]   <= o_sts.zero_len;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            fpe_pkg::DP_LOAD: begin
                r_mat[{i_column_index, i_row_index}] <= i_element_value;
            end
            fpe_pkg::DP_LATCH_PT: begin
                r_px <= i_point_x;
                r_py <= i_point_y;
                r_pz <= i_point_z;
            end
            fpe_pkg::DP_GATHER: begin
                if (!i_cmd.step[0])
                    r_w <= mat_rd;
                else
                    r_v[i_cmd.step[2:1]] <= fpe_pkg::plane_add(i_cmd.plane) ? ext_w + ext_e
                                                                            : ext_w - ext_e;
            end
            fpe_pkg::DP_ACCUM: begin
                if (i_cmd.step[1:0] != 2'd3) begin
                    r_prod <= mul_p;
                    r_sqh  <= sq_mag[SW-1] & ~i_cmd.query;
                end
                if (i_cmd.step[1:0] == 2'd0)
                    r_acc <= i_cmd.query ? HALF_LSB : '0;
                else
                    r_acc <= r_acc + acc_add;
            end
            fpe_pkg::DP_SQRT_INIT: begin
                r_sval <= {2'b00, r_acc};
                r_srem <= '0;
                r_root <= '0;
            end
            fpe_pkg::DP_SQRT_STEP: begin
                r_sval <= r_sval << 2;
                if (srem_sh >= strial) begin
                    r_srem <= srem_sh - strial;
                    r_root <= {r_root[RW-2:0], 1'b1};
                end else begin
                    r_srem <= srem_sh;
                    r_root <= {r_root[RW-2:0], 1'b0};
                end
            end
            fpe_pkg::DP_DIV_INIT: begin
                r_neg <= div_v[SW-1];
                r_nq  <= {div_mag, {FRACTION_BITS{1'b0}}};
                r_rem <= '0;
            end
            fpe_pkg::DP_DIV_STEP: begin
                r_rem <= dtrial[RW] ? rem_sh[RW-1:0] : dtrial[RW-1:0];
                r_nq  <= {r_nq[NW-2:0], ~dtrial[RW]};
            end
            fpe_pkg::DP_DIV_STORE: begin
                r_res[i_cmd.comp] <= q_sat;
            end
            fpe_pkg::DP_PLANE_WR: begin
                r_pln[i_cmd.plane] <= o_sts.zero_len ? '0
                                      : {r_res[3], r_res[2], r_res[1], r_res[0]};
                r_dist <= '0;
            end
            fpe_pkg::DP_QFIN: begin
                r_dist <= dist_sat;
            end
            default: ;
        endcase
    end

    assign o_sts.zero_len  = (r_acc == '0);

    assign o_plane_index    = i_cmd.plane;
    assign o_normal_x       = pln_rd[0];
    assign o_normal_y       = pln_rd[1];
    assign o_normal_z       = pln_rd[2];
    assign o_plane_offset   = pln_rd[3];
    assign o_point_distance = r_dist;
    assign o_degenerate     = r_degen[i_cmd.plane];
    assign o_last_result    = (i_cmd.plane == fpe_pkg::LAST_PLANE);

endmodule

`default_nettype wire
